>>> rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types, codes and a helper function for the string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int unsigned ByteW = 8;

    // Decoder modes.
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_ESCAPE = 2'd2;
    localparam logic [1:0] MODE_HEX    = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NO_QUOTE    = 3'd0;
    localparam logic [2:0] ERR_UNTERM_ESC  = 3'd1;
    localparam logic [2:0] ERR_BAD_ESC     = 3'd2;
    localparam logic [2:0] ERR_SHORT_UNI   = 3'd3;
    localparam logic [2:0] ERR_BAD_HEX     = 3'd4;
    localparam logic [2:0] ERR_UNTERM_STR  = 3'd5;

    // Characters of interest.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // UTF-8 encoding constants.
    localparam logic [15:0] UTF_MAX1  = 16'h007F;
    localparam logic [15:0] UTF_MAX2  = 16'h07FF;
    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_CONT  = 8'h80;
    localparam logic [5:0]  UTF_MASK  = 6'h3F;

    typedef struct packed {
        logic             eot;
        logic [ByteW-1:0] text;
    } t_item;

    // A group of up to three results caused by one input item.
    typedef struct packed {
        logic [1:0]                cnt;
        logic [1:0]                kind;
        logic [2:0]                err;
        logic [2:0][ByteW-1:0]     bytes;
    } t_group;

    // Returns {valid, value} for one ASCII hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

>>> rtl/jsu_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted request until the decoder consumes it.
// ----------------------------------------------------------------------------
module jsu_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  jsu_pkg::t_item i_item,
    input  logic          i_take,
    output logic          o_valid,
    output jsu_pkg::t_item o_item
);
    import jsu_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// Escape decoder
// Holds the string state and turns one byte into a group of results.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  jsu_pkg::t_item  i_item,
    output jsu_pkg::t_group o_group
);
    import jsu_pkg::*;

    logic [1:0]  r_mode;
    logic [1:0]  n_mode;
    logic [1:0]  r_hex_cnt;
    logic [1:0]  n_hex_cnt;
    logic [15:0] r_cp;
    logic [15:0] n_cp;
    logic [4:0]  hex;
    logic [15:0] cp_full;
    t_group      grp;

    assign hex     = hex_digit(i_item.text);
    assign cp_full = {r_cp[11:0], hex[3:0]};

    always_comb begin
        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        n_cp      = r_cp;
        grp       = '0;
        case (r_mode)
            MODE_IDLE: begin
                if (i_item.eot || i_item.text != CH_QUOTE) begin
                    grp.cnt  = 2'd1;
                    grp.kind = KIND_ERROR;
                    grp.err  = ERR_NO_QUOTE;
                end else begin
                    n_mode = MODE_STRING;
                end
            end
            MODE_STRING: begin
                if (i_item.eot) begin
                    grp.cnt  = 2'd1;
                    grp.kind = KIND_ERROR;
                    grp.err  = ERR_UNTERM_STR;
                    n_mode   = MODE_IDLE;
                end else if (i_item.text == CH_QUOTE) begin
                    grp.cnt  = 2'd1;
                    grp.kind = KIND_DONE;
                    n_mode   = MODE_IDLE;
                end else if (i_item.text == CH_BSLASH) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    grp.cnt      = 2'd1;
                    grp.kind     = KIND_BYTE;
                    grp.bytes[0] = i_item.text;
                end
            end
            MODE_ESCAPE: begin
                grp.cnt  = 2'd1;
                grp.kind = KIND_BYTE;
                n_mode   = MODE_STRING;
                if (i_item.eot) begin
                    grp.kind = KIND_ERROR;
                    grp.err  = ERR_UNTERM_ESC;
                    n_mode   = MODE_IDLE;
                end else begin
                    case (i_item.text)
                        CH_QUOTE:  grp.bytes[0] = 8'h22;
                        CH_BSLASH: grp.bytes[0] = 8'h5C;
                        CH_SLASH:  grp.bytes[0] = 8'h2F;
                        CH_B:      grp.bytes[0] = 8'h08;
                        CH_F:      grp.bytes[0] = 8'h0C;
                        CH_N:      grp.bytes[0] = 8'h0A;
                        CH_R:      grp.bytes[0] = 8'h0D;
                        CH_T:      grp.bytes[0] = 8'h09;
                        CH_U: begin
                            grp.cnt   = 2'd0;
                            n_mode    = MODE_HEX;
                            n_hex_cnt = 2'd0;
                            n_cp      = 16'd0;
                        end
                        default: begin
                            grp.kind = KIND_ERROR;
                            grp.err  = ERR_BAD_ESC;
                            n_mode   = MODE_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                if (i_item.eot || !hex[4]) begin
                    grp.cnt   = 2'd1;
                    grp.kind  = KIND_ERROR;
                    grp.err   = i_item.eot ? ERR_SHORT_UNI : ERR_BAD_HEX;
                    n_mode    = MODE_IDLE;
                    n_hex_cnt = 2'd0;
                    n_cp      = 16'd0;
                end else if (r_hex_cnt != 2'd3) begin
                    n_cp      = cp_full;
                    n_hex_cnt = r_hex_cnt + 2'd1;
                end else begin
                    grp.kind  = KIND_BYTE;
                    n_mode    = MODE_STRING;
                    n_hex_cnt = 2'd0;
                    n_cp      = 16'd0;
                    if (cp_full <= UTF_MAX1) begin
                        grp.cnt      = 2'd1;
                        grp.bytes[0] = cp_full[7:0];
                    end else if (cp_full <= UTF_MAX2) begin
                        grp.cnt      = 2'd2;
                        grp.bytes[0] = UTF_LEAD2 | {3'd0, cp_full[10:6]};
                        grp.bytes[1] = UTF_CONT | {2'd0, cp_full[5:0] & UTF_MASK};
                    end else begin
                        grp.cnt      = 2'd3;
                        grp.bytes[0] = UTF_LEAD3 | {4'd0, cp_full[15:12]};
                        grp.bytes[1] = UTF_CONT | {2'd0, cp_full[11:6] & UTF_MASK};
                        grp.bytes[2] = UTF_CONT | {2'd0, cp_full[5:0] & UTF_MASK};
                    end
                end
            end
        endcase
    end

    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_hex_cnt <= 2'd0;
            r_cp      <= 16'd0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_cp      <= n_cp;
        end
    end

endmodule

>>> rtl/jsu_out_buf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Registers one result group and hands its results out one at a time.
// ----------------------------------------------------------------------------
module jsu_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  jsu_pkg::t_group i_group,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_data,
    output logic [2:0]      o_err,
    output logic            o_last
);
    import jsu_pkg::*;

    logic   r_valid;
    logic   n_valid;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    t_group r_grp;
    logic   take;
    logic   last_beat;

    assign take      = r_valid && i_ready;
    assign last_beat = r_idx == (r_grp.cnt - 2'd1);
    assign o_free    = !r_valid || (take && last_beat);

    assign o_valid = r_valid;
    assign o_kind  = r_grp.kind;
    assign o_err   = r_grp.err;
    assign o_last  = last_beat;

    always_comb begin
        case (r_idx)
            2'd1:    o_data = r_grp.bytes[1];
            2'd2:    o_data = r_grp.bytes[2];
            default: o_data = r_grp.bytes[0];
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = 2'd0;
        end else if (take) begin
            if (last_beat) begin
                n_valid = 1'b0;
                n_idx   = 2'd0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_group;
        end
    end

endmodule

>>> rtl/json_string_unescape.sv
// A request waits in the input register until the result buffer is free to register
// its results. Throughput: one request per cycle while each causes at most one result
// and the receiver is ready; a request that causes two or three bytes holds the single
// result register until all are taken, and one without results does not load it.
// Reset: synchronous, active low; it returns the decoder to awaiting the opening
// quote and empties the input and result registers.
// ----------------------------------------------------------------------------
// JSON string unescape
// Decodes the escapes of one JSON string literal into plain and UTF-8 bytes.
// ----------------------------------------------------------------------------
module json_string_unescape (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [10:8] error_code, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);
    import jsu_pkg::*;

    t_item  in_item;
    t_item  held_item;
    t_group grp;
    logic   held_valid;
    logic   out_free;
    logic   step;
    logic [7:0] out_data;
    logic [2:0] out_err;

    assign in_item.eot  = s_axis_tuser;
    assign in_item.text = s_axis_tdata;

    // The decoder moves on only when the result buffer can take its group.
    assign step = held_valid && out_free;

    jsu_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (held_item),
        .o_group (grp)
    );

    jsu_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && (grp.cnt != 2'd0)),
        .i_group (grp),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_data  (out_data),
        .o_err   (out_err),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_err, out_data};

endmodule

>>> tb/tb_json_string_unescape.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescape testbench
// Streams well-formed, broken and stray JSON string text into the decoder.
// Every accepted request is run through a behavioural decoder, and each
// result is checked against the oldest byte, end or error that it predicted.
// ----------------------------------------------------------------------------
module tb_json_string_unescape;

    import jsu_pkg::*;

    localparam int unsigned RandomRequests = 420;
    localparam int unsigned IdleLimit      = 2000;
    localparam int unsigned HoldCycles     = 300;
    localparam int unsigned HoldAfter      = 120;
    localparam int unsigned DrainCycles    = 10;
    localparam int unsigned MaxReports     = 10;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] err;
        logic       last;
    } t_decoded;

    typedef struct {
        logic [7:0] text;
        logic       eot;
    } t_request;

    // Returns {valid, value} for an ASCII hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, c[3:0]};
        end else if (c >= "a" && c <= "f") begin
            return {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            return {1'b1, 4'(c - "A" + 8'd10)};
        end
        return 5'd0;
    endfunction

    // Returns {valid, byte} for the letter after a backslash; 'u' is not included.
    function automatic logic [8:0] escape_target(input logic [7:0] c);
        case (c)
            CH_QUOTE:  return {1'b1, CH_QUOTE};
            CH_BSLASH: return {1'b1, CH_BSLASH};
            CH_SLASH:  return {1'b1, CH_SLASH};
            CH_B:      return {1'b1, 8'h08};
            CH_F:      return {1'b1, 8'h0C};
            CH_N:      return {1'b1, 8'h0A};
            CH_R:      return {1'b1, 8'h0D};
            CH_T:      return {1'b1, 8'h09};
            default:   return 9'd0;
        endcase
    endfunction

    class unescape_scoreboard;
        logic [1:0]  mode;
        logic [1:0]  digits;
        logic [15:0] code_acc;
        t_decoded    decoded_q[$];
        int          fails;

        function new();
            clear();
            fails = 0;
        endfunction

        function void clear();
            mode     = MODE_IDLE;
            digits   = 2'd0;
            code_acc = 16'd0;
        endfunction

        function void push(logic [1:0] kind, logic [7:0] data, logic [2:0] err, logic last);
            t_decoded r;
            r.kind = kind;
            r.data = data;
            r.err  = err;
            r.last = last;
            decoded_q = {decoded_q, r};
        endfunction

        function void raise_error(logic [2:0] code);
            clear();
            push(KIND_ERROR, 8'd0, code, 1'b1);
        endfunction

        // Advances the decoder by one accepted request and queues what it gives.
        function void note_request(logic [7:0] c, logic eot);
            logic [8:0]  esc;
            logic [4:0]  nib;
            logic [15:0] cp;
            case (mode)
                MODE_IDLE: begin
                    if (eot || c != CH_QUOTE) raise_error(ERR_NO_QUOTE);
                    else mode = MODE_STRING;
                end
                MODE_STRING: begin
                    if (eot) begin
                        raise_error(ERR_UNTERM_STR);
                    end else if (c == CH_QUOTE) begin
                        clear();
                        push(KIND_DONE, 8'd0, 3'd0, 1'b1);
                    end else if (c == CH_BSLASH) begin
                        mode = MODE_ESCAPE;
                    end else begin
                        push(KIND_BYTE, c, 3'd0, 1'b1);
                    end
                end
                MODE_ESCAPE: begin
                    esc = escape_target(c);
                    if (eot) begin
                        raise_error(ERR_UNTERM_ESC);
                    end else if (c == CH_U) begin
                        mode     = MODE_HEX;
                        digits   = 2'd0;
                        code_acc = 16'd0;
                    end else if (esc[8]) begin
                        mode = MODE_STRING;
                        push(KIND_BYTE, esc[7:0], 3'd0, 1'b1);
                    end else begin
                        raise_error(ERR_BAD_ESC);
                    end
                end
                default: begin
                    nib = hex_nibble(c);
                    cp  = {code_acc[11:0], nib[3:0]};
                    if (eot) begin
                        raise_error(ERR_SHORT_UNI);
                    end else if (!nib[4]) begin
                        raise_error(ERR_BAD_HEX);
                    end else if (digits != 2'd3) begin
                        code_acc = cp;
                        digits   = digits + 2'd1;
                    end else begin
                        if (cp <= UTF_MAX1) begin
                            push(KIND_BYTE, cp[7:0], 3'd0, 1'b1);
                        end else if (cp <= UTF_MAX2) begin
                            push(KIND_BYTE, UTF_LEAD2 | {3'd0, cp[10:6]}, 3'd0, 1'b0);
                            push(KIND_BYTE, UTF_CONT | {2'd0, cp[5:0]}, 3'd0, 1'b1);
                        end else begin
                            push(KIND_BYTE, UTF_LEAD3 | {4'd0, cp[15:12]}, 3'd0, 1'b0);
                            push(KIND_BYTE, UTF_CONT | {2'd0, cp[11:6]}, 3'd0, 1'b0);
                            push(KIND_BYTE, UTF_CONT | {2'd0, cp[5:0]}, 3'd0, 1'b1);
                        end
                        mode     = MODE_STRING;
                        digits   = 2'd0;
                        code_acc = 16'd0;
                    end
                end
            endcase
        endfunction

        function void check_result(logic [15:0] tdata, logic [1:0] kind, logic last);
            t_decoded e;
            if (decoded_q.size() == 0) begin
                fails++;
                if (fails <= MaxReports)
                    $display("unexpected result: kind %0d data %02h err %0d last %0b",
                             kind, tdata[7:0], tdata[10:8], last);
                return;
            end
            e = decoded_q.pop_front();
            if (kind !== e.kind || tdata[7:0] !== e.data || tdata[10:8] !== e.err ||
                tdata[15:11] !== 5'd0 || last !== e.last) begin
                fails++;
                if (fails <= MaxReports) begin
                    $display("mismatch: expected kind %0d data %02h err %0d last %0b",
                             e.kind, e.data, e.err, e.last);
                    $display("          got kind %0d data %02h err %0d last %0b pad %02h",
                             kind, tdata[7:0], tdata[10:8], last, tdata[15:11]);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] text_byte
    logic        s_axis_tuser;   // [0] end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] data_byte, [10:8] error_code, rest zero
    logic [1:0]  m_axis_tuser;   // [1:0] kind
    logic        m_axis_tlast;

    unescape_scoreboard sb = new();
    t_request           text_q[$];
    int unsigned        requests_in = 0;
    int unsigned        idle_cycles = 0;

    json_string_unescape uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void add_req(logic [7:0] text, logic eot);
        t_request r;
        r.text = text;
        r.eot  = eot;
        text_q = {text_q, r};
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_req(s[i], 1'b0);
    endfunction

    function automatic void add_hex_digit(logic [3:0] n);
        if (n < 4'd10) add_req(8'h30 + n, 1'b0);
        else if ($urandom_range(0, 1)) add_req("a" + n - 8'd10, 1'b0);
        else add_req("A" + n - 8'd10, 1'b0);
    endfunction

    // Random strings: mostly well formed, some cut short or broken, some stray text.
    task automatic build_random(int unsigned count);
        logic [7:0]  esc_letters [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                         CH_F, CH_N, CH_R, CH_T};
        logic [15:0] cp_extremes [6] = '{16'h0000, 16'h007F, 16'h0080,
                                         16'h07FF, 16'h0800, 16'hFFFF};
        int unsigned goal;
        int unsigned nseg;
        int unsigned k;
        logic [7:0]  b;
        logic [15:0] cp;
        goal = text_q.size() + count;
        while (text_q.size() < goal) begin
            if ($urandom_range(0, 99) < 6) begin
                repeat ($urandom_range(1, 3))
                    add_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            add_req(CH_QUOTE, 1'b0);
            nseg = $urandom_range(0, 8);
            for (int s = 0; s < nseg; s++) begin
                k = $urandom_range(0, 9);
                if (k < 4) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
                    add_req(b, 1'b0);
                end else if (k < 7) begin
                    add_req(CH_BSLASH, 1'b0);
                    add_req(esc_letters[$urandom_range(0, 7)], 1'b0);
                end else begin
                    case ($urandom_range(0, 5))
                        0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
                        1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                        3:       cp = cp_extremes[$urandom_range(0, 5)];
                        default: cp = 16'($urandom_range(0, 16'hFFFF));
                    endcase
                    add_req(CH_BSLASH, 1'b0);
                    add_req(CH_U, 1'b0);
                    for (int d = 3; d >= 0; d--) add_hex_digit(cp[d*4 +: 4]);
                end
            end
            if ($urandom_range(0, 99) < 80) begin
                add_req(CH_QUOTE, 1'b0);
            end else begin
                case ($urandom_range(0, 4))
                    0: add_req(8'($urandom_range(0, 255)), 1'b1);
                    1: begin
                        add_req(CH_BSLASH, 1'b0);
                        add_req(8'($urandom_range(0, 255)), 1'b1);
                    end
                    2: begin
                        do b = 8'($urandom_range(0, 255));
                        while (escape_target(b) != 9'd0 || b == CH_U);
                        add_req(CH_BSLASH, 1'b0);
                        add_req(b, 1'b0);
                    end
                    default: begin
                        add_req(CH_BSLASH, 1'b0);
                        add_req(CH_U, 1'b0);
                        repeat ($urandom_range(0, 3))
                            add_hex_digit(4'($urandom_range(0, 15)));
                        if ($urandom_range(0, 1)) begin
                            add_req(8'($urandom_range(0, 255)), 1'b1);
                        end else begin
                            do b = 8'($urandom_range(0, 255));
                            while (hex_nibble(b) != 5'd0);
                            add_req(b, 1'b0);
                        end
                    end
                endcase
            end
        end
    endtask

    task automatic send_request(t_request r);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.text;
        s_axis_tuser  <= r.eot;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Sender works in bursts with random gaps, some of them empty.
    task automatic drive_text();
        int unsigned idx;
        int unsigned burst;
        int unsigned gap;
        idx = 0;
        while (idx < text_q.size()) begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && idx < text_q.size(); i++) begin
                send_request(text_q[idx]);
                idx++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Receiver stall pattern, with one long hold-off once the run is under way.
    initial begin : receiver
        int unsigned cyc;
        int unsigned hold_left;
        bit          held;
        cyc           = 0;
        hold_left     = 0;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!held && requests_in >= HoldAfter) begin
                held      = 1'b1;
                hold_left = HoldCycles;
                m_axis_tready <= 1'b0;
            end else begin
                case ((cyc / 50) % 4)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (cyc % 4) != 0;
                    default: m_axis_tready <= $urandom_range(0, 9) != 0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(s_axis_tdata, s_axis_tuser);
                requests_in++;
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("tb_json_string_unescape NOT OK");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;

        // Stray text before any string, then the extremes and each error path.
        add_req(8'($urandom_range(0, 255)), 1'b1);
        add_text("A");
        add_text("\"");
        add_req(8'h00, 1'b0);
        add_req(8'hFF, 1'b0);
        add_text("\\n\\uFfFf\"");
        add_text("\"");
        add_req(8'hA5, 1'b1);
        add_text("\"\\");
        add_req(8'h5A, 1'b1);
        add_text("\"\\q");
        add_text("\"\\u0");
        add_req(8'h00, 1'b1);
        add_text("\"\\ug");
        build_random(RandomRequests);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        drive_text();
        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (sb.fails == 0) begin
            $display("tb_json_string_unescape OK");
        end else begin
            $display("tb_json_string_unescape NOT OK");
        end
        $finish;
    end

endmodule
